### hw/rtl/fovr_pkg.sv
package fovr_pkg;

   // angle format: signed radians scaled by 2^-24
   localparam int AW = 29;
   // vectoring datapath width
   localparam int VW = 38;
   // rotation datapath width, sine and cosine scaled by 2^-30
   localparam int XW = 32;

   localparam logic signed [AW-1:0] ANG_PI      = 29'sd52707179;
   localparam logic signed [AW-1:0] ANG_TWO_PI  = 29'sd105414357;
   localparam logic signed [AW-1:0] ANG_HALF_PI = 29'sd26353589;
   localparam logic signed [AW-1:0] ANG_TEN_DEG = 29'sd2928177;
   localparam logic signed [XW-1:0] GAIN_INV    = 32'sd652032874;

   typedef enum logic {
      TAG_YAW,
      TAG_PITCH
   } vec_tag_type;

   // one vectoring (atan2) slot of the cell chain
   typedef struct packed {
      logic                   valid;
      vec_tag_type            tag;
      logic signed [VW-1:0]   x;
      logic signed [VW-1:0]   y;
      logic signed [AW-1:0]   z;
   } vec_type;

   // one ray slot of the rotation chain: yaw and pitch rotate side by side
   typedef struct packed {
      logic                   valid;
      logic                   last;
      logic signed [31:0]     pos_x;
      logic signed [31:0]     pos_y;
      logic signed [31:0]     pos_z;
      logic signed [AW-1:0]   ya;
      logic signed [XW-1:0]   yx;
      logic signed [XW-1:0]   yy;
      logic                   yneg;
      logic signed [AW-1:0]   pa;
      logic signed [XW-1:0]   px;
      logic signed [XW-1:0]   py;
      logic                   pneg;
   } rot_type;

   // atan(2^-i) in the angle format
   function automatic logic signed [AW-1:0] atan_entry(input logic [4:0] idx);
      logic signed [AW-1:0] v;
      case (idx)
         5'd0:    v = 29'sd13176795;
         5'd1:    v = 29'sd7778716;
         5'd2:    v = 29'sd4110060;
         5'd3:    v = 29'sd2086331;
         5'd4:    v = 29'sd1047214;
         5'd5:    v = 29'sd524117;
         5'd6:    v = 29'sd262123;
         5'd7:    v = 29'sd131069;
         5'd8:    v = 29'sd65536;
         5'd9:    v = 29'sd32768;
         5'd10:   v = 29'sd16384;
         5'd11:   v = 29'sd8192;
         5'd12:   v = 29'sd4096;
         5'd13:   v = 29'sd2048;
         5'd14:   v = 29'sd1024;
         5'd15:   v = 29'sd512;
         5'd16:   v = 29'sd256;
         5'd17:   v = 29'sd128;
         5'd18:   v = 29'sd64;
         5'd19:   v = 29'sd32;
         5'd20:   v = 29'sd16;
         5'd21:   v = 29'sd8;
         5'd22:   v = 29'sd4;
         5'd23:   v = 29'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### hw/rtl/fovr_vec_cell.sv
module fovr_vec_cell
   import fovr_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic    clock,
   input  logic    reset,
   input  vec_type vec_in,
   output vec_type vec_out
);

   vec_type cell_ff;
   vec_type cell_in;

   // one vectoring micro-rotation, driving y toward zero
   always_comb begin
      cell_in = vec_in;
      if (vec_in.y[VW-1]) begin
         cell_in.x = vec_in.x - (vec_in.y >>> STAGE);
         cell_in.y = vec_in.y + (vec_in.x >>> STAGE);
         cell_in.z = vec_in.z - atan_entry(5'(STAGE));
      end else begin
         cell_in.x = vec_in.x + (vec_in.y >>> STAGE);
         cell_in.y = vec_in.y - (vec_in.x >>> STAGE);
         cell_in.z = vec_in.z + atan_entry(5'(STAGE));
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end
   end

   assign vec_out = cell_ff;

endmodule

### hw/rtl/fovr_rot_cell.sv
module fovr_rot_cell
   import fovr_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  rot_type rot_in,
   output rot_type rot_out
);

   rot_type cell_ff;
   rot_type cell_in;

   // one rotation step each for the yaw and the pitch angle
   always_comb begin
      cell_in = rot_in;
      if (rot_in.ya[AW-1]) begin
         cell_in.yx = rot_in.yx + (rot_in.yy >>> STAGE);
         cell_in.yy = rot_in.yy - (rot_in.yx >>> STAGE);
         cell_in.ya = rot_in.ya + atan_entry(5'(STAGE));
      end else begin
         cell_in.yx = rot_in.yx - (rot_in.yy >>> STAGE);
         cell_in.yy = rot_in.yy + (rot_in.yx >>> STAGE);
         cell_in.ya = rot_in.ya - atan_entry(5'(STAGE));
      end
      if (rot_in.pa[AW-1]) begin
         cell_in.px = rot_in.px + (rot_in.py >>> STAGE);
         cell_in.py = rot_in.py - (rot_in.px >>> STAGE);
         cell_in.pa = rot_in.pa + atan_entry(5'(STAGE));
      end else begin
         cell_in.px = rot_in.px - (rot_in.py >>> STAGE);
         cell_in.py = rot_in.py + (rot_in.px >>> STAGE);
         cell_in.pa = rot_in.pa - atan_entry(5'(STAGE));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
      end
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end
   end

   assign rot_out = cell_ff;

endmodule

### hw/rtl/fovr_isqrt.sv
module fovr_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [56:0] value,
   output logic        done,
   output logic [28:0] root
);

   localparam int STEPS = 29;

   logic [57:0] val_ff;
   logic [29:0] acc_ff;
   logic [28:0] root_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [31:0] acc_sh;
   logic [31:0] trial;
   logic [31:0] acc_in;
   logic [28:0] root_in;

   // restoring square root, two radicand bits per step
   always_comb begin
      acc_sh = {acc_ff, val_ff[57:56]};
      trial  = {1'b0, root_ff, 2'b01};
      if (acc_sh >= trial) begin
         acc_in  = acc_sh - trial;
         root_in = {root_ff[27:0], 1'b1};
      end else begin
         acc_in  = acc_sh;
         root_in = {root_ff[27:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (start) begin
         val_ff  <= {1'b0, value};
         acc_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= '0;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         val_ff  <= val_ff << 2;
         acc_ff  <= 30'(acc_in);
         root_ff <= root_in;
         cnt_ff  <= cnt_ff + 5'd1;
         if (cnt_ff == 5'(STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### hw/rtl/fov_ray_endpoint_generator_unit.sv
// Ray fan generator: each pose (Q16.16 position, Q2.14 quaternion) yields
// (2h+1)(2v+1) ray end points, h and v being floor(fov/20) capped at 3, so
// 1 to 49 rays, horizontal offset outer and vertical inner, last_ray on the
// final one. A pose is taken into a one-deep buffer and solved: quaternion
// products, then the shared atan2 cell chain for the yaw and, unless the
// pitch is clamped to +-pi/2, after a 29-step square root for the pitch.
// Rays then leave one per cycle while the output is not stalled, through a
// rotation cell chain of CORDIC_STAGES cells plus five register stages:
// issue and fold before the cells, product, scale and output after them.
// The solver works on the next pose while the fan emits the current one.
// An output stall on a valid ray freezes the whole ray pipeline.
module fov_ray_endpoint_generator_unit
   import fovr_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_quat_w,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_end_x,
   output logic signed [31:0] rsp_end_y,
   output logic signed [31:0] rsp_end_z,
   output logic               rsp_last_ray,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_wdata
);

   localparam int SW = 34;

   localparam logic [1:0] CSR_FOV_H = 2'd0;
   localparam logic [1:0] CSR_FOV_V = 2'd1;
   localparam logic [1:0] CSR_RANGE = 2'd2;

   localparam logic signed [SW-1:0] ONE_Q28 = 34'sd268435456;
   localparam logic signed [57:0]   ONE_Q56 = 58'sd72057594037927936;
   localparam logic signed [63:0]   RND64   = 64'sd536870912;
   localparam logic signed [57:0]   RND58   = 58'sd536870912;

   typedef enum logic [2:0] {
      FE_IDLE,
      FE_MUL,
      FE_SUM,
      FE_SQ,
      FE_RSTART,
      FE_ROOT,
      FE_WAIT,
      FE_HAND
   } fe_state_type;

   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic signed [31:0]   pos_x;
      logic signed [31:0]   pos_y;
      logic signed [31:0]   pos_z;
      logic signed [AW-1:0] ya;
      logic signed [AW-1:0] pa;
   } ray_type;

   typedef struct packed {
      logic               valid;
      logic               last;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [63:0] prod_x;
      logic signed [63:0] prod_y;
      logic signed [31:0] spt;
   } dir_type;

   typedef struct packed {
      logic               valid;
      logic               last;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [57:0] off_x;
      logic signed [57:0] off_y;
      logic signed [57:0] off_z;
   } off_type;

   // half step count: floor(fov / 20), capped at 3
   function automatic logic signed [2:0] half_steps(input logic [6:0] fov);
      logic signed [2:0] h;
      if (fov >= 7'd60) h = 3'sd3;
      else if (fov >= 7'd40) h = 3'sd2;
      else if (fov >= 7'd20) h = 3'sd1;
      else h = 3'sd0;
      return h;
   endfunction

   // grid offset in angle units for a step of -3..3
   function automatic logic signed [AW-1:0] ten_step(input logic signed [2:0] s);
      logic signed [AW-1:0] v;
      case (s)
         -3'sd3:  v = -29'sd8784531;
         -3'sd2:  v = -29'sd5856354;
         -3'sd1:  v = -29'sd2928177;
         3'sd1:   v = 29'sd2928177;
         3'sd2:   v = 29'sd5856354;
         3'sd3:   v = 29'sd8784531;
         default: v = '0;
      endcase
      return v;
   endfunction

   // atan2 front: half-plane flip for negative x
   function automatic vec_type vec_prep(input logic signed [SW-1:0] y,
                                        input logic signed [SW-1:0] x,
                                        input vec_tag_type tag);
      vec_type v;
      v.valid = 1'b1;
      v.tag   = tag;
      v.x     = VW'(x);
      v.y     = VW'(y);
      v.z     = '0;
      if (x[SW-1]) begin
         v.z = y[SW-1] ? -ANG_PI : ANG_PI;
         v.x = -v.x;
         v.y = -v.y;
      end
      return v;
   endfunction

   // wrap into +-pi, then fold into +-pi/2 with a sign flag
   function automatic logic [AW:0] fold_angle(input logic signed [AW-1:0] ang);
      logic signed [AW-1:0] a;
      logic                 neg;
      a   = ang;
      neg = 1'b0;
      if (a > ANG_PI) a = a - ANG_TWO_PI;
      if (a < -ANG_PI) a = a + ANG_TWO_PI;
      if (a > ANG_HALF_PI) begin
         a   = a - ANG_PI;
         neg = 1'b1;
      end else if (a < -ANG_HALF_PI) begin
         a   = a + ANG_PI;
         neg = 1'b1;
      end
      return {neg, a};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > 35'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -35'sd2147483648) r = 32'sh80000000;
      else r = 32'(v);
      return r;
   endfunction

   // configuration registers
   logic [6:0]  fov_h_ff;
   logic [6:0]  fov_v_ff;
   logic [23:0] range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fov_h_ff <= 7'd60;
         fov_v_ff <= 7'd45;
         range_ff <= 24'd655360;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FOV_H: fov_h_ff <= csr_wdata[6:0];
            CSR_FOV_V: fov_v_ff <= csr_wdata[6:0];
            CSR_RANGE: range_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input buffer, frees the channel while a pose is solved
   logic               buf_valid_ff;
   logic signed [31:0] buf_pos_x_ff, buf_pos_y_ff, buf_pos_z_ff;
   logic signed [15:0] buf_qx_ff, buf_qy_ff, buf_qz_ff, buf_qw_ff;

   fe_state_type fe_state_ff;

   always_ff @(posedge clock) begin
      if (req_valid && !buf_valid_ff) begin
         buf_valid_ff <= 1'b1;
         buf_pos_x_ff <= req_pos_x;
         buf_pos_y_ff <= req_pos_y;
         buf_pos_z_ff <= req_pos_z;
         buf_qx_ff    <= req_quat_x;
         buf_qy_ff    <= req_quat_y;
         buf_qz_ff    <= req_quat_z;
         buf_qw_ff    <= req_quat_w;
      end else if (fe_state_ff == FE_IDLE) begin
         buf_valid_ff <= 1'b0;
      end
      if (reset) begin
         buf_valid_ff <= 1'b0;
      end
   end

   assign req_stall = buf_valid_ff;

   // pose solver
   logic signed [31:0]   fe_pos_x_ff, fe_pos_y_ff, fe_pos_z_ff;
   logic signed [15:0]   qx_ff, qy_ff, qz_ff, qw_ff;
   logic signed [31:0]   p_wz_ff, p_xy_ff, p_yy_ff, p_zz_ff, p_wy_ff, p_zx_ff;
   logic signed [SW-1:0] sy_ff, cy_ff, sp_ff;
   logic signed [57:0]   sq_ff;
   logic                 yaw_zero_ff;
   logic                 yaw_done_ff, pitch_done_ff;
   logic signed [AW-1:0] yaw_ff, pitch_ff;
   logic                 fan_active_ff;

   logic        sqrt_start;
   logic [56:0] sqrt_value;
   logic        sqrt_done;
   logic [28:0] sqrt_root;

   vec_type vec_chain [CORDIC_STAGES+1];
   vec_type vec_out;

   assign vec_out    = vec_chain[CORDIC_STAGES];
   assign sqrt_start = (fe_state_ff == FE_RSTART);
   assign sqrt_value = 57'(ONE_Q56 - sq_ff);

   always_ff @(posedge clock) begin
      case (fe_state_ff)
         FE_IDLE: begin
            if (buf_valid_ff) begin
               fe_pos_x_ff   <= buf_pos_x_ff;
               fe_pos_y_ff   <= buf_pos_y_ff;
               fe_pos_z_ff   <= buf_pos_z_ff;
               qx_ff         <= buf_qx_ff;
               qy_ff         <= buf_qy_ff;
               qz_ff         <= buf_qz_ff;
               qw_ff         <= buf_qw_ff;
               yaw_done_ff   <= 1'b0;
               pitch_done_ff <= 1'b0;
               fe_state_ff   <= FE_MUL;
            end
         end
         FE_MUL: begin
            p_wz_ff     <= 32'(qw_ff) * 32'(qz_ff);
            p_xy_ff     <= 32'(qx_ff) * 32'(qy_ff);
            p_yy_ff     <= 32'(qy_ff) * 32'(qy_ff);
            p_zz_ff     <= 32'(qz_ff) * 32'(qz_ff);
            p_wy_ff     <= 32'(qw_ff) * 32'(qy_ff);
            p_zx_ff     <= 32'(qz_ff) * 32'(qx_ff);
            fe_state_ff <= FE_SUM;
         end
         FE_SUM: begin
            sy_ff       <= (SW'(p_wz_ff) + SW'(p_xy_ff)) <<< 1;
            cy_ff       <= ONE_Q28 - ((SW'(p_yy_ff) + SW'(p_zz_ff)) <<< 1);
            sp_ff       <= (SW'(p_wy_ff) - SW'(p_zx_ff)) <<< 1;
            fe_state_ff <= FE_SQ;
         end
         FE_SQ: begin
            // yaw enters the vectoring chain in this state
            yaw_zero_ff <= (sy_ff == '0) && (cy_ff == '0);
            sq_ff       <= 58'(29'(sp_ff)) * 58'(29'(sp_ff));
            if (sp_ff >= ONE_Q28) begin
               pitch_ff      <= ANG_HALF_PI;
               pitch_done_ff <= 1'b1;
               fe_state_ff   <= FE_WAIT;
            end else if (sp_ff <= -ONE_Q28) begin
               pitch_ff      <= -ANG_HALF_PI;
               pitch_done_ff <= 1'b1;
               fe_state_ff   <= FE_WAIT;
            end else begin
               fe_state_ff <= FE_RSTART;
            end
         end
         FE_RSTART: begin
            fe_state_ff <= FE_ROOT;
         end
         FE_ROOT: begin
            if (sqrt_done) begin
               fe_state_ff <= FE_WAIT;
            end
         end
         FE_WAIT: begin
            if (yaw_done_ff && pitch_done_ff) begin
               fe_state_ff <= FE_HAND;
            end
         end
         FE_HAND: begin
            if (!fan_active_ff) begin
               fe_state_ff <= FE_IDLE;
            end
         end
         default: begin
            fe_state_ff <= FE_IDLE;
         end
      endcase
      // collect angles leaving the vectoring chain
      if (vec_out.valid && vec_out.tag == TAG_YAW) begin
         yaw_ff      <= yaw_zero_ff ? '0 : vec_out.z;
         yaw_done_ff <= 1'b1;
      end
      if (vec_out.valid && vec_out.tag == TAG_PITCH) begin
         pitch_ff      <= vec_out.z;
         pitch_done_ff <= 1'b1;
      end
      if (reset) begin
         fe_state_ff   <= FE_IDLE;
         yaw_done_ff   <= 1'b0;
         pitch_done_ff <= 1'b0;
      end
   end

   fovr_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (sqrt_value),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   // launch into the shared atan2 chain
   always_comb begin
      vec_chain[0] = '0;
      if (fe_state_ff == FE_SQ) begin
         vec_chain[0] = vec_prep(sy_ff, cy_ff, TAG_YAW);
      end else if (fe_state_ff == FE_ROOT && sqrt_done) begin
         vec_chain[0] = vec_prep(sp_ff, $signed({5'b0, sqrt_root}), TAG_PITCH);
      end
   end

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
      fovr_vec_cell #(.STAGE(k)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .vec_in  (vec_chain[k]),
         .vec_out (vec_chain[k+1])
      );
   end

   // ray pipeline advances unless a finished ray waits on a stalled output
   logic en;
   logic rsp_valid_ff;
   assign en = !(rsp_valid_ff && rsp_stall);

   // fan sequencer
   logic signed [2:0]    fan_i_ff, fan_j_ff, fan_hh_ff, fan_vh_ff;
   logic signed [AW-1:0] fan_yaw_ff, fan_pitch_ff;
   logic signed [31:0]   fan_pos_x_ff, fan_pos_y_ff, fan_pos_z_ff;
   logic                 fan_load;
   logic                 fan_last;

   assign fan_load = (fe_state_ff == FE_HAND) && !fan_active_ff;
   assign fan_last = (fan_i_ff == fan_hh_ff) && (fan_j_ff == fan_vh_ff);

   always_ff @(posedge clock) begin
      if (fan_load) begin
         fan_active_ff <= 1'b1;
         fan_hh_ff     <= half_steps(fov_h_ff);
         fan_vh_ff     <= half_steps(fov_v_ff);
         fan_i_ff      <= -half_steps(fov_h_ff);
         fan_j_ff      <= -half_steps(fov_v_ff);
         fan_yaw_ff    <= yaw_ff;
         fan_pitch_ff  <= pitch_ff;
         fan_pos_x_ff  <= fe_pos_x_ff;
         fan_pos_y_ff  <= fe_pos_y_ff;
         fan_pos_z_ff  <= fe_pos_z_ff;
      end else if (fan_active_ff && en) begin
         if (fan_j_ff == fan_vh_ff) begin
            fan_j_ff <= -fan_vh_ff;
            if (fan_i_ff == fan_hh_ff) begin
               fan_active_ff <= 1'b0;
            end else begin
               fan_i_ff <= fan_i_ff + 3'sd1;
            end
         end else begin
            fan_j_ff <= fan_j_ff + 3'sd1;
         end
      end
      if (reset) begin
         fan_active_ff <= 1'b0;
      end
   end

   // issue and fold stages
   ray_type issue_ff;
   rot_type rot_chain [CORDIC_STAGES+1];

   always_ff @(posedge clock) begin
      if (en) begin
         issue_ff.valid <= fan_active_ff;
         issue_ff.last  <= fan_last;
         issue_ff.pos_x <= fan_pos_x_ff;
         issue_ff.pos_y <= fan_pos_y_ff;
         issue_ff.pos_z <= fan_pos_z_ff;
         issue_ff.ya    <= fan_yaw_ff + ten_step(fan_i_ff);
         issue_ff.pa    <= fan_pitch_ff + ten_step(fan_j_ff);
      end
      if (reset) begin
         issue_ff.valid <= 1'b0;
      end
   end

   rot_type fold_ff;
   rot_type fold_in;

   always_comb begin
      fold_in.valid           = issue_ff.valid;
      fold_in.last            = issue_ff.last;
      fold_in.pos_x           = issue_ff.pos_x;
      fold_in.pos_y           = issue_ff.pos_y;
      fold_in.pos_z           = issue_ff.pos_z;
      {fold_in.yneg, fold_in.ya} = fold_angle(issue_ff.ya);
      {fold_in.pneg, fold_in.pa} = fold_angle(issue_ff.pa);
      fold_in.yx              = GAIN_INV;
      fold_in.yy              = '0;
      fold_in.px              = GAIN_INV;
      fold_in.py              = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fold_ff <= fold_in;
      end
      if (reset) begin
         fold_ff.valid <= 1'b0;
      end
   end

   assign rot_chain[0] = fold_ff;

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
      fovr_rot_cell #(.STAGE(k)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .rot_in  (rot_chain[k]),
         .rot_out (rot_chain[k+1])
      );
   end

   // direction products cos(p) cos(y), cos(p) sin(y)
   rot_type              rot_out;
   logic signed [XW-1:0] cyw, syw, cp, spt;
   dir_type              dir_ff;

   assign rot_out = rot_chain[CORDIC_STAGES];
   assign cyw     = rot_out.yneg ? -rot_out.yx : rot_out.yx;
   assign syw     = rot_out.yneg ? -rot_out.yy : rot_out.yy;
   assign cp      = rot_out.pneg ? -rot_out.px : rot_out.px;
   assign spt     = rot_out.pneg ? -rot_out.py : rot_out.py;

   always_ff @(posedge clock) begin
      if (en) begin
         dir_ff.valid  <= rot_out.valid;
         dir_ff.last   <= rot_out.last;
         dir_ff.pos_x  <= rot_out.pos_x;
         dir_ff.pos_y  <= rot_out.pos_y;
         dir_ff.pos_z  <= rot_out.pos_z;
         dir_ff.prod_x <= 64'(cp) * 64'(cyw);
         dir_ff.prod_y <= 64'(cp) * 64'(syw);
         dir_ff.spt    <= spt;
      end
      if (reset) begin
         dir_ff.valid <= 1'b0;
      end
   end

   // round direction, scale by range
   logic signed [32:0] dx, dy;
   logic signed [24:0] range_s;
   off_type            off_ff;

   assign dx      = 33'((dir_ff.prod_x + RND64) >>> 30);
   assign dy      = 33'((dir_ff.prod_y + RND64) >>> 30);
   assign range_s = $signed({1'b0, range_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         off_ff.valid <= dir_ff.valid;
         off_ff.last  <= dir_ff.last;
         off_ff.pos_x <= dir_ff.pos_x;
         off_ff.pos_y <= dir_ff.pos_y;
         off_ff.pos_z <= dir_ff.pos_z;
         off_ff.off_x <= 58'(dx) * 58'(range_s);
         off_ff.off_y <= 58'(dy) * 58'(range_s);
         off_ff.off_z <= 58'(dir_ff.spt) * 58'(range_s);
      end
      if (reset) begin
         off_ff.valid <= 1'b0;
      end
   end

   // round offset, add origin, saturate into the output register
   logic signed [33:0] ox, oy, oz;
   logic signed [31:0] rsp_end_x_ff, rsp_end_y_ff, rsp_end_z_ff;
   logic               rsp_last_ff;

   assign ox = 34'((off_ff.off_x + RND58) >>> 30);
   assign oy = 34'((off_ff.off_y + RND58) >>> 30);
   assign oz = 34'((off_ff.off_z + RND58) >>> 30);

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_valid_ff <= off_ff.valid;
         rsp_last_ff  <= off_ff.last;
         rsp_end_x_ff <= sat32(35'(off_ff.pos_x) + 35'(ox));
         rsp_end_y_ff <= sat32(35'(off_ff.pos_y) + 35'(oy));
         rsp_end_z_ff <= sat32(35'(off_ff.pos_z) + 35'(oz));
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_end_x    = rsp_end_x_ff;
   assign rsp_end_y    = rsp_end_y_ff;
   assign rsp_end_z    = rsp_end_z_ff;
   assign rsp_last_ray = rsp_last_ff;

`ifndef SYNTHESIS
   // a pose handed over always starts a fan
   a_fan_load: assert property (@(posedge clock) disable iff (reset)
      (fe_state_ff == FE_HAND && !fan_active_ff) |=> fan_active_ff)
      else $error("fan did not start on pose handoff");

   // the pitch angle only comes back while the solver waits for it
   a_pitch_wait: assert property (@(posedge clock) disable iff (reset)
      (vec_out.valid && vec_out.tag == TAG_PITCH) |-> (fe_state_ff == FE_WAIT))
      else $error("pitch result outside wait state");

   // grid counters stay inside the fan
   a_fan_range: assert property (@(posedge clock) disable iff (reset)
      fan_active_ff |-> (fan_i_ff <= fan_hh_ff && fan_j_ff <= fan_vh_ff))
      else $error("fan counter past its limit");
`endif

endmodule
